// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the PID altitude throttle block.
// No dependencies; files that assert take this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is asserted (active low).
`define PAT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define PAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/pat_pkg.sv
// Shared widths, reset values, register indexes and handshake structs of the
// PID altitude throttle block. No dependencies.
package pat_pkg;

    // Field widths.
    localparam int GAIN_W     = 24;
    localparam int ALT_W      = 32;
    localparam int RATE_W     = 10;
    localparam int PERIOD_W   = 16;
    localparam int INTEG_W    = 19;
    localparam int THR_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Serial multiplier widths: signed multiplicand, signed multiplier and an
    // accumulator wide enough for three gain products summed.
    localparam int MCAND_W   = 33;
    localparam int MPLIER_W  = 24;
    localparam int ACC_W     = 58;
    localparam int MUL_CNT_W = $clog2(MPLIER_W);
    localparam int FRAC_W    = 16;

    // Register reset values.
    localparam logic [GAIN_W-1:0]   GAIN_P_RST = 24'd6554;
    localparam logic [GAIN_W-1:0]   GAIN_I_RST = 24'd655;
    localparam logic [GAIN_W-1:0]   GAIN_D_RST = 24'd13107;
    localparam logic [ALT_W-1:0]    TARGET_RST = 32'd6553600;
    localparam logic [RATE_W-1:0]   RATE_RST   = 10'd50;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1311;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd5;

    // Input word commands.
    localparam logic CMD_ALT  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Clamp limits: integral within +-2.0, throttle within [0.0, 1.0].
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 19'sd131072;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = -19'sd131072;
    localparam logic [THR_W-1:0]          THR_MAX   = 17'd65536;

    // Controller to multiplier.
    typedef struct packed {
        logic start;
        logic clear;
    } t_mul_ctrl;

    // Multiplier to controller.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

// File: hw/rtl/pat_serial_mul.sv
// Bit-serial signed shift-and-add multiplier with a running accumulator.
// Depends on pat_pkg for widths and the control and status structs.
module pat_serial_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pat_pkg::t_mul_ctrl                    i_ctrl,
    input  logic signed [pat_pkg::MCAND_W-1:0]    i_mcand,
    input  logic signed [pat_pkg::MPLIER_W-1:0]   i_mplier,
    output pat_pkg::t_mul_stat                    o_stat,
    output logic signed [pat_pkg::ACC_W-1:0]      o_acc
);

    localparam logic [pat_pkg::MUL_CNT_W-1:0] LAST_BIT =
        pat_pkg::MUL_CNT_W'(pat_pkg::MPLIER_W - 1);

    logic                                 r_busy;
    logic                                 r_done;
    logic [pat_pkg::MUL_CNT_W-1:0]        r_cnt;
    logic signed [pat_pkg::ACC_W-1:0]     r_mc;
    logic [pat_pkg::MPLIER_W-1:0]         r_mp;
    logic signed [pat_pkg::ACC_W-1:0]     r_acc;
    logic                                 w_last;
    logic signed [pat_pkg::ACC_W-1:0]     w_addend;
    logic signed [pat_pkg::ACC_W-1:0]     n_acc;

    // One multiplier bit per cycle; the sign bit carries negative weight.
    assign w_last   = (r_cnt == LAST_BIT);
    assign w_addend = r_mp[0] ? r_mc : '0;
    assign n_acc    = w_last ? (r_acc - w_addend) : (r_acc + w_addend);

    // Sequencing of the bit count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Operand shift registers and the accumulator.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_mc <= pat_pkg::ACC_W'(i_mcand);
            r_mp <= i_mplier;
            if (i_ctrl.clear) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_mc  <= r_mc <<< 1;
            r_mp  <= r_mp >> 1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_acc       = r_acc;

endmodule

// File: hw/rtl/pid_altitude_throttle.sv
// Top level of the PID altitude throttle block: registers, sequencer, clamps.
// Depends on pat_pkg, pat_serial_mul and assert_macros.svh.
//
//  channel   direction  handshake               payload
//  in        input      i_in_valid/o_in_stall   i_cmd, i_altitude
//  out       output     o_out_valid/i_out_stall o_throttle
//  cfg       input      i_cfg_we                i_cfg_index, i_cfg_data
//
// An altitude word only updates the held altitude. A tick word runs five
// products through one bit-serial multiplier at one bit per cycle, plus the
// error, handoff and output steps.
// Reset is synchronous and restores the register defaults and zero state.
// A stalled result waits in the output register; the next input word is
// taken meanwhile, and a tick only stalls in its output state S_OUT if the
// output register is still full.

`include "assert_macros.svh"

module pid_altitude_throttle (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_cmd,
    input  logic signed [pat_pkg::ALT_W-1:0]   i_altitude,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pat_pkg::THR_W-1:0]          o_throttle,
    input  logic                               i_cfg_we,
    input  logic [pat_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pat_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_START_I = 3'd1;
    localparam logic [2:0] S_WAIT_I  = 3'd2;
    localparam logic [2:0] S_WAIT_D  = 3'd3;
    localparam logic [2:0] S_WAIT_P  = 3'd4;
    localparam logic [2:0] S_WAIT_II = 3'd5;
    localparam logic [2:0] S_WAIT_DD = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    localparam int Q_W = pat_pkg::ACC_W - pat_pkg::FRAC_W;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [pat_pkg::ACC_W-1:0] v);
        logic [pat_pkg::ACC_W-32:0] top;
        top = v[pat_pkg::ACC_W-1:31];
        if ((&top) || !(|top)) begin
            return v[31:0];
        end else if (v[pat_pkg::ACC_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

    // Configuration registers.
    logic signed [pat_pkg::GAIN_W-1:0]   r_gain_p;
    logic signed [pat_pkg::GAIN_W-1:0]   r_gain_i;
    logic signed [pat_pkg::GAIN_W-1:0]   r_gain_d;
    logic signed [pat_pkg::ALT_W-1:0]    r_target;
    logic [pat_pkg::RATE_W-1:0]          r_rate;
    logic [pat_pkg::PERIOD_W-1:0]        r_period;

    // Controller state and working values.
    logic [2:0]                          r_state;
    logic [2:0]                          n_state;
    logic signed [pat_pkg::ALT_W-1:0]    r_altitude;
    logic signed [pat_pkg::INTEG_W-1:0]  r_integral;
    logic signed [pat_pkg::ALT_W-1:0]    r_last_error;
    logic signed [pat_pkg::ALT_W-1:0]    r_err;
    logic signed [pat_pkg::INTEG_W-1:0]  r_integ;
    logic signed [pat_pkg::ALT_W-1:0]    r_deriv;
    logic                                r_out_valid;
    logic [pat_pkg::THR_W-1:0]           r_throttle;

    logic                                w_in_acc;
    logic                                w_out_free;
    logic signed [pat_pkg::ACC_W-1:0]    w_err_wide;
    logic signed [Q_W-1:0]               w_acc_q;
    logic signed [Q_W:0]                 w_integ_sum;
    logic signed [pat_pkg::INTEG_W-1:0]  w_integ_clamp;
    logic [pat_pkg::THR_W-1:0]           w_thr;

    pat_pkg::t_mul_ctrl                      w_mul_ctrl;
    pat_pkg::t_mul_stat                      w_mul_stat;
    logic signed [pat_pkg::MCAND_W-1:0]      w_mcand;
    logic signed [pat_pkg::MPLIER_W-1:0]     w_mplier;
    logic signed [pat_pkg::ACC_W-1:0]        w_acc;

    pat_serial_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_mul_ctrl),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_stat   (w_mul_stat),
        .o_acc    (w_acc)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_throttle  = r_throttle;

    // Error: target minus altitude, saturated.
    assign w_err_wide = pat_pkg::ACC_W'(r_target) - pat_pkg::ACC_W'(r_altitude);

    // Floor shift of the product by the fraction width.
    assign w_acc_q = w_acc[pat_pkg::ACC_W-1:pat_pkg::FRAC_W];

    // Integral step and clamp to +-2.0.
    always_comb begin
        w_integ_sum = (Q_W + 1)'(r_integral) + (Q_W + 1)'(w_acc_q);
        if (w_integ_sum > (Q_W + 1)'(pat_pkg::INTEG_MAX)) begin
            w_integ_clamp = pat_pkg::INTEG_MAX;
        end else if (w_integ_sum < (Q_W + 1)'(pat_pkg::INTEG_MIN)) begin
            w_integ_clamp = pat_pkg::INTEG_MIN;
        end else begin
            w_integ_clamp = w_integ_sum[pat_pkg::INTEG_W-1:0];
        end
    end

    // Throttle clamp to [0.0, 1.0].
    always_comb begin
        if (w_acc_q < 0) begin
            w_thr = '0;
        end else if (w_acc_q > Q_W'(signed'({1'b0, pat_pkg::THR_MAX}))) begin
            w_thr = pat_pkg::THR_MAX;
        end else begin
            w_thr = w_acc_q[pat_pkg::THR_W-1:0];
        end
    end

    // Multiplier operand selection and handoff from one product to the next.
    always_comb begin
        w_mul_ctrl = '0;
        w_mcand    = '0;
        w_mplier   = '0;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_cmd == pat_pkg::CMD_TICK)) begin
                    n_state = S_START_I;
                end
            end
            S_START_I: begin
                w_mul_ctrl = '{start: 1'b1, clear: 1'b1};
                w_mcand    = pat_pkg::MCAND_W'(r_err);
                w_mplier   = pat_pkg::MPLIER_W'(r_period);
                n_state    = S_WAIT_I;
            end
            S_WAIT_I: begin
                w_mcand  = pat_pkg::MCAND_W'(r_err) - pat_pkg::MCAND_W'(r_last_error);
                w_mplier = pat_pkg::MPLIER_W'(r_rate);
                if (w_mul_stat.done) begin
                    w_mul_ctrl = '{start: 1'b1, clear: 1'b1};
                    n_state    = S_WAIT_D;
                end
            end
            S_WAIT_D: begin
                w_mcand  = pat_pkg::MCAND_W'(r_err);
                w_mplier = r_gain_p;
                if (w_mul_stat.done) begin
                    w_mul_ctrl = '{start: 1'b1, clear: 1'b1};
                    n_state    = S_WAIT_P;
                end
            end
            S_WAIT_P: begin
                w_mcand  = pat_pkg::MCAND_W'(r_integ);
                w_mplier = r_gain_i;
                if (w_mul_stat.done) begin
                    w_mul_ctrl = '{start: 1'b1, clear: 1'b0};
                    n_state    = S_WAIT_II;
                end
            end
            S_WAIT_II: begin
                w_mcand  = pat_pkg::MCAND_W'(r_deriv);
                w_mplier = r_gain_d;
                if (w_mul_stat.done) begin
                    w_mul_ctrl = '{start: 1'b1, clear: 1'b0};
                    n_state    = S_WAIT_DD;
                end
            end
            S_WAIT_DD: begin
                if (w_mul_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, configuration and stored controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_gain_p     <= pat_pkg::GAIN_P_RST;
            r_gain_i     <= pat_pkg::GAIN_I_RST;
            r_gain_d     <= pat_pkg::GAIN_D_RST;
            r_target     <= pat_pkg::TARGET_RST;
            r_rate       <= pat_pkg::RATE_RST;
            r_period     <= pat_pkg::PERIOD_RST;
            r_altitude   <= '0;
            r_integral   <= '0;
            r_last_error <= '0;
        end else begin
            r_state <= n_state;
            // The result register fills at the end of a tick and empties when taken.
            r_out_valid <= (r_state == S_OUT && w_out_free) ||
                           (r_out_valid && i_out_stall);
            if (r_state == S_OUT && w_out_free) begin
                r_integral   <= r_integ;
                r_last_error <= r_err;
            end
            if (w_in_acc && (i_cmd == pat_pkg::CMD_ALT)) begin
                r_altitude <= i_altitude;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pat_pkg::REG_GAIN_P: r_gain_p <= i_cfg_data[pat_pkg::GAIN_W-1:0];
                    pat_pkg::REG_GAIN_I: r_gain_i <= i_cfg_data[pat_pkg::GAIN_W-1:0];
                    pat_pkg::REG_GAIN_D: r_gain_d <= i_cfg_data[pat_pkg::GAIN_W-1:0];
                    pat_pkg::REG_TARGET: r_target <= i_cfg_data[pat_pkg::ALT_W-1:0];
                    pat_pkg::REG_RATE:   r_rate   <= i_cfg_data[pat_pkg::RATE_W-1:0];
                    pat_pkg::REG_PERIOD: r_period <= i_cfg_data[pat_pkg::PERIOD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working values of one tick.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_cmd == pat_pkg::CMD_TICK)) begin
            r_err <= sat32(w_err_wide);
        end
        if (r_state == S_WAIT_I && w_mul_stat.done) begin
            r_integ <= w_integ_clamp;
        end
        if (r_state == S_WAIT_D && w_mul_stat.done) begin
            r_deriv <= sat32(w_acc);
        end
        if (r_state == S_OUT && w_out_free) begin
            r_throttle <= w_thr;
        end
    end

    // Checks.
    `PAT_ASSERT(a_thr_range, i_clk, i_rst_n,
        o_out_valid |-> (o_throttle <= pat_pkg::THR_MAX), "throttle above 1.0")
    `PAT_ASSERT(a_integ_range, i_clk, i_rst_n,
        (r_integral <= pat_pkg::INTEG_MAX) && (r_integral >= pat_pkg::INTEG_MIN),
        "integral outside clamp")
    `PAT_ASSERT(a_idle_mul, i_clk, i_rst_n,
        (r_state == S_IDLE) |-> !w_mul_stat.busy, "multiplier busy while idle")
    `PAT_ASSERT(a_tick_stall, i_clk, i_rst_n,
        (w_in_acc && i_cmd == pat_pkg::CMD_TICK) |=> o_in_stall, "tick did not start")

endmodule

// File: dv/pat_throttle_checker.sv
// Checker for the PID altitude throttle block: watches the input, output and
// register channels, predicts each throttle word and compares it.
// Depends on pat_pkg for widths, register indexes, commands and clamp limits.
module pat_throttle_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic                               i_cmd,
    input  logic signed [pat_pkg::ALT_W-1:0]   i_altitude,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [pat_pkg::THR_W-1:0]          i_throttle,
    input  logic                               i_cfg_we,
    input  logic [pat_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pat_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_throttle_count
);

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    // Shadow copy of the registers and of the controller state.
    logic signed [pat_pkg::GAIN_W-1:0]  kp;
    logic signed [pat_pkg::GAIN_W-1:0]  ki;
    logic signed [pat_pkg::GAIN_W-1:0]  kd;
    logic signed [pat_pkg::ALT_W-1:0]   setpoint;
    logic [pat_pkg::RATE_W-1:0]         rate;
    logic [pat_pkg::PERIOD_W-1:0]       period;
    logic signed [pat_pkg::ALT_W-1:0]   alt_hold;
    logic signed [pat_pkg::INTEG_W-1:0] integ_acc;
    logic signed [pat_pkg::ALT_W-1:0]   prev_err;

    // Throttle words predicted but not yet seen on the output.
    logic [pat_pkg::THR_W-1:0] throttle_q[$];

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // One control tick: updates integral and last error, returns the throttle.
    function automatic logic [pat_pkg::THR_W-1:0] pid_tick_throttle();
        longint e;
        longint isum;
        longint slope;
        longint acc;
        e     = sat(longint'(setpoint) - longint'(alt_hold), S32_MIN, S32_MAX);
        isum  = longint'(integ_acc) + ((e * $signed({1'b0, period})) >>> pat_pkg::FRAC_W);
        isum  = sat(isum, longint'(pat_pkg::INTEG_MIN), longint'(pat_pkg::INTEG_MAX));
        slope = sat((e - longint'(prev_err)) * $signed({1'b0, rate}), S32_MIN, S32_MAX);
        acc   = longint'(kp) * e + longint'(ki) * isum + longint'(kd) * slope;
        acc   = sat(acc >>> pat_pkg::FRAC_W, 0, longint'(pat_pkg::THR_MAX));
        integ_acc = isum[pat_pkg::INTEG_W-1:0];
        prev_err  = e[pat_pkg::ALT_W-1:0];
        return acc[pat_pkg::THR_W-1:0];
    endfunction

    // Register writes, accepted input words and accepted throttle words,
    // all sampled at the rising edge.
    always @(posedge i_clk) begin
        logic [pat_pkg::THR_W-1:0] exp_thr;
        if (!i_rst_n) begin
            kp        = pat_pkg::GAIN_P_RST;
            ki        = pat_pkg::GAIN_I_RST;
            kd        = pat_pkg::GAIN_D_RST;
            setpoint  = pat_pkg::TARGET_RST;
            rate      = pat_pkg::RATE_RST;
            period    = pat_pkg::PERIOD_RST;
            alt_hold  = '0;
            integ_acc = '0;
            prev_err  = '0;
            throttle_q.delete();
            o_fail_count     = 0;
            o_throttle_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pat_pkg::REG_GAIN_P: kp       = i_cfg_data[pat_pkg::GAIN_W-1:0];
                    pat_pkg::REG_GAIN_I: ki       = i_cfg_data[pat_pkg::GAIN_W-1:0];
                    pat_pkg::REG_GAIN_D: kd       = i_cfg_data[pat_pkg::GAIN_W-1:0];
                    pat_pkg::REG_TARGET: setpoint = i_cfg_data[pat_pkg::ALT_W-1:0];
                    pat_pkg::REG_RATE:   rate     = i_cfg_data[pat_pkg::RATE_W-1:0];
                    pat_pkg::REG_PERIOD: period   = i_cfg_data[pat_pkg::PERIOD_W-1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                if (i_cmd == pat_pkg::CMD_TICK) begin
                    throttle_q.push_back(pid_tick_throttle());
                end else begin
                    alt_hold = i_altitude;
                end
            end

            if (i_out_valid && !i_out_stall) begin
                if (throttle_q.size() == 0) begin
                    $error("throttle: no word expected, actual %0d", i_throttle);
                    o_fail_count++;
                end else begin
                    exp_thr = throttle_q.pop_front();
                    o_throttle_count++;
                    if (i_throttle !== exp_thr) begin
                        $error("throttle: expected %0d, actual %0d", exp_thr, i_throttle);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = throttle_q.size();
    end

endmodule

// File: dv/tb_top.sv
// Testbench top for the PID altitude throttle block: clock, reset, input and
// register stimulus, receiver stalls and the verdict.
// Depends on pat_pkg, pid_altitude_throttle and pat_throttle_checker.
module tb_top;

    localparam int     SETTLE_CYCLES   = 160;
    localparam int     RANDOM_PHASES   = 8;
    localparam int     WORDS_PER_PHASE = 125;
    localparam int     LONG_HOLD       = 700;
    localparam longint RUN_LIMIT       = 10_000_000;

    // Indexes with no register behind them; writes there must be ignored.
    localparam logic [pat_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [pat_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 in_valid  = 1'b0;
    logic                                 in_stall;
    logic                                 cmd       = pat_pkg::CMD_ALT;
    logic signed [pat_pkg::ALT_W-1:0]     altitude  = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic [pat_pkg::THR_W-1:0]            throttle;
    logic                                 cfg_we    = 1'b0;
    logic [pat_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [pat_pkg::CFG_DATA_W-1:0]       cfg_data  = '0;

    int fails;
    int pending;
    int throttles_seen;

    // Stimulus knobs shared with the receiver process.
    int                        gap_odds      = 5;
    int                        stall_odds    = 5;
    int                        hold_len      = 0;
    bit                        quiet_tail    = 1'b0;
    logic [pat_pkg::ALT_W-1:0] cur_target    = pat_pkg::TARGET_RST;
    int                        words_sent    = 0;
    int                        reg_writes    = 0;
    int                        settings_used = 1;

    always #5 clk = ~clk;

    pid_altitude_throttle u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_cmd       (cmd),
        .i_altitude  (altitude),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_throttle  (throttle),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pat_throttle_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_cmd            (cmd),
        .i_altitude       (altitude),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_throttle       (throttle),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fails),
        .o_pending        (pending),
        .o_throttle_count (throttles_seen)
    );

    // Offer one word, after an optional random gap, and wait until it is taken.
    // Starts and ends at a falling edge; valid stays high for the next word.
    task automatic put_word(input logic c, input logic [pat_pkg::ALT_W-1:0] a);
        if (!quiet_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        altitude <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    // Stop sending, wait for every throttle word, then let a trailing
    // altitude word finish before registers change.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all six registers back to back, optionally also the spare indexes.
    task automatic load_settings(input logic [pat_pkg::CFG_DATA_W-1:0] p,
                                 input logic [pat_pkg::CFG_DATA_W-1:0] i,
                                 input logic [pat_pkg::CFG_DATA_W-1:0] d,
                                 input logic [pat_pkg::CFG_DATA_W-1:0] tgt,
                                 input logic [pat_pkg::CFG_DATA_W-1:0] rt,
                                 input logic [pat_pkg::CFG_DATA_W-1:0] per,
                                 input bit spare);
        logic [pat_pkg::CFG_DATA_W-1:0] vals[6];
        logic [pat_pkg::CFG_IDX_W-1:0]  regs[6];
        vals = '{p, i, d, tgt, rt, per};
        regs = '{pat_pkg::REG_GAIN_P, pat_pkg::REG_GAIN_I, pat_pkg::REG_GAIN_D,
                 pat_pkg::REG_TARGET, pat_pkg::REG_RATE, pat_pkg::REG_PERIOD};
        for (int k = 0; k < 6; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(negedge clk);
        end
        if (spare) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_SPARE_A;
            cfg_data  <= $urandom();
            @(negedge clk);
            cfg_index <= REG_SPARE_B;
            cfg_data  <= $urandom();
            @(negedge clk);
            reg_writes += 2;
        end
        cfg_we <= 1'b0;
        cur_target = tgt;
        reg_writes += 6;
        settings_used++;
    endtask

    // Receiver: short random stall bursts, or one long hold when asked.
    initial begin : out_side
        int n;
        forever begin
            @(negedge clk);
            if (hold_len > 0) begin
                n = hold_len;
                hold_len = 0;
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end else if (!quiet_tail && stall_odds != 0 &&
                         $urandom_range(1, stall_odds) == 1) begin
                n = $urandom_range(1, 4);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        #RUN_LIMIT;
        $display("FAIL pid_altitude_throttle");
        $finish;
    end

    initial begin : stim
        int ph;
        int k;
        int sel;
        logic [pat_pkg::ALT_W-1:0] word_alt;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero altitude, zero error, then both altitude extremes.
        put_word(pat_pkg::CMD_TICK, $urandom());
        put_word(pat_pkg::CMD_ALT, pat_pkg::TARGET_RST);
        put_word(pat_pkg::CMD_TICK, $urandom());
        put_word(pat_pkg::CMD_ALT, 32'h8000_0000);
        put_word(pat_pkg::CMD_TICK, $urandom());
        put_word(pat_pkg::CMD_ALT, 32'h7FFF_FFFF);
        put_word(pat_pkg::CMD_TICK, $urandom());

        // Largest gains and period, rate 1000 and the highest setpoint: the error
        // saturates, the integral clamps high, and a full swing of the error
        // saturates the derivative. Spare indexes are written as well.
        drain();
        load_settings(32'h007F_FFFF, 32'h007F_FFFF, 32'h007F_FFFF, 32'h7FFF_FFFF,
                      32'd1000, 32'd65535, 1'b1);
        put_word(pat_pkg::CMD_ALT, 32'h8000_0000);
        put_word(pat_pkg::CMD_TICK, $urandom());
        put_word(pat_pkg::CMD_TICK, $urandom());
        put_word(pat_pkg::CMD_ALT, 32'h7FFF_FFFF);
        put_word(pat_pkg::CMD_TICK, $urandom());

        // Most negative gains and setpoint, zero rate and zero period.
        drain();
        load_settings(32'hFF80_0000, 32'h0080_0000, 32'h0080_0000, 32'h8000_0000,
                      32'd0, 32'd0, 1'b0);
        put_word(pat_pkg::CMD_ALT, 32'h7FFF_FFFF);
        put_word(pat_pkg::CMD_TICK, $urandom());
        put_word(pat_pkg::CMD_TICK, $urandom());
        put_word(pat_pkg::CMD_ALT, 32'h0000_0000);
        put_word(pat_pkg::CMD_TICK, $urandom());

        // Unity proportional gain with a rate and period that do not match.
        drain();
        load_settings(32'd65536, 32'd0, 32'd0, 32'd0, 32'd1023, 32'd1, 1'b0);
        put_word(pat_pkg::CMD_ALT, 32'hFFFF_8000);
        put_word(pat_pkg::CMD_TICK, $urandom());
        put_word(pat_pkg::CMD_ALT, 32'h0001_0000);
        put_word(pat_pkg::CMD_TICK, $urandom());

        // Random phases: ticks and altitudes at even odds, altitudes mostly near the setpoint.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            gap_odds   = (ph == 1) ? 0 : 5;
            stall_odds = (ph == 1) ? 0 : 5;
            quiet_tail = (ph == RANDOM_PHASES - 1);
            if (ph % 3 == 2) begin
                load_settings($urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom(), 1'b0);
            end else begin
                load_settings($urandom_range(0, 131072) - 65536,
                              $urandom_range(0, 262144) - 131072,
                              $urandom_range(0, 2048) - 1024,
                              $urandom_range(0, 33554432) - 16777216,
                              $urandom_range(1, 100), $urandom_range(1, 65535), 1'b0);
            end
            // Long output hold while words keep coming, so the block backs up.
            if (ph == 2) hold_len = LONG_HOLD;
            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                sel = $urandom_range(0, 9);
                if (sel < 5) begin
                    put_word(pat_pkg::CMD_TICK, $urandom());
                end else begin
                    sel = $urandom_range(0, 9);
                    if (sel < 6)
                        word_alt = cur_target + ($urandom_range(0, 131072) - 65536);
                    else if (sel < 9)
                        word_alt = $urandom();
                    else
                        word_alt = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    put_word(pat_pkg::CMD_ALT, word_alt);
                end
            end
        end

        // Wait for the last throttle words, then a quiet stretch.
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Run sent %0d input words and checked %0d throttle words,",
                 words_sent, throttles_seen);
        $display("over %0d register settings with %0d register writes.",
                 settings_used, reg_writes);
        if (fails == 0)
            $display("PASS pid_altitude_throttle");
        else
            $display("FAIL pid_altitude_throttle");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/pat_pkg.sv
hw/rtl/pat_serial_mul.sv
hw/rtl/pid_altitude_throttle.sv
dv/pat_throttle_checker.sv
dv/tb_top.sv
